// ----- sv/cube_map_face_select_defines.svh -----
// ----------------------------------------------------------------------------
// Cube-map face select: assertion macros
// Shared concurrent assertion forms; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_SELECT_DEFINES_SVH
`define CUBE_MAP_FACE_SELECT_DEFINES_SVH

// same-cycle implication
`define CMFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Cube-map face select: package
// Widths, face codes, pipeline stage types and helpers.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    localparam int COMP_BITS  = 16;
    localparam int UV_BITS    = 16;
    localparam int MAG_W      = COMP_BITS;
    localparam int EXT_W      = COMP_BITS + 1;
    localparam int REM_W      = COMP_BITS + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (UV_BITS + DIV_STEPS - 1) / DIV_STEPS;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } cmfs_face_t;

    typedef struct packed {
        cmfs_face_t face;
        logic       zero;
        logic       sat_u;
        logic       sat_v;
    } cmfs_side_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] x;
        logic signed [COMP_BITS-1:0] y;
        logic signed [COMP_BITS-1:0] z;
        logic                        x_major;
        logic                        y_major;
        logic                        zero;
    } cmfs_s1_t;

    typedef struct packed {
        cmfs_side_t           side;
        logic [MAG_W-1:0]     ma;
        logic [REM_W-1:0]     rem_u;
        logic [REM_W-1:0]     rem_v;
        logic [UV_BITS-1:0]   quo_u;
        logic [UV_BITS-1:0]   quo_v;
    } cmfs_div_t;

    function automatic logic [MAG_W-1:0] comp_mag(logic signed [COMP_BITS-1:0] a);
        return a[COMP_BITS-1] ? MAG_W'(-a) : MAG_W'(a);
    endfunction

endpackage

// ----- sv/cmfs_if.sv -----
// ----------------------------------------------------------------------------
// Cube-map face select: channel interfaces
// Direction request channel and face/uv result channel, valid/ready.
// ----------------------------------------------------------------------------
interface cmfs_in_if import cmfs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_out_if import cmfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         face;
    logic [UV_BITS-1:0] u_coord;
    logic [UV_BITS-1:0] v_coord;
    logic               zero_vector;

    modport source (output valid, output face, output u_coord, output v_coord,
                    output zero_vector, input ready);
    modport sink   (input valid, input face, input u_coord, input v_coord,
                    input zero_vector, output ready);
endinterface

// ----- sv/cmfs_divider.sv -----
// ----------------------------------------------------------------------------
// Cube-map face select: pipelined divider
// Restoring division of u and v numerators by the major magnitude,
// DIV_STEPS quotient bits per stage, shared enable for stalls.
// ----------------------------------------------------------------------------
`include "cube_map_face_select_defines.svh"

module cmfs_divider import cmfs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cmfs_div_t in_data,
    output logic      out_valid,
    output cmfs_div_t out_data
);

    logic      vld_reg  [DIV_STAGES];
    cmfs_div_t stg_reg  [DIV_STAGES];
    cmfs_div_t stg_next [DIV_STAGES];
    logic      vld_in   [DIV_STAGES];
    cmfs_div_t stg_in   [DIV_STAGES];

    function automatic cmfs_div_t div_step(cmfs_div_t d);
        cmfs_div_t r;
        r = d;
        if (d.rem_u >= REM_W'(d.ma))
        begin
            r.rem_u = d.rem_u - REM_W'(d.ma);
            r.quo_u = {d.quo_u[UV_BITS-2:0], 1'b1};
        end
        else
        begin
            r.quo_u = {d.quo_u[UV_BITS-2:0], 1'b0};
        end
        if (d.rem_v >= REM_W'(d.ma))
        begin
            r.rem_v = d.rem_v - REM_W'(d.ma);
            r.quo_v = {d.quo_v[UV_BITS-2:0], 1'b1};
        end
        else
        begin
            r.quo_v = {d.quo_v[UV_BITS-2:0], 1'b0};
        end
        r.rem_u = r.rem_u << 1;
        r.rem_v = r.rem_v << 1;
        return r;
    endfunction

    assign vld_in[0] = in_valid;
    assign stg_in[0] = in_data;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        if (k > 0)
        begin : g_link
            assign vld_in[k] = vld_reg[k-1];
            assign stg_in[k] = stg_reg[k-1];
        end

        always_comb
        begin
            stg_next[k] = stg_in[k];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                if (k * DIV_STEPS + i < UV_BITS)
                begin
                    stg_next[k] = div_step(stg_next[k]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end

        // remainder stays below twice the divisor unless the coordinate saturates
        `CMFS_ASSERT_IMP(a_rem_bound, vld_reg[k] && !stg_reg[k].side.zero,
            (stg_reg[k].side.sat_u || stg_reg[k].rem_u < (REM_W'(stg_reg[k].ma) << 1)) &&
            (stg_reg[k].side.sat_v || stg_reg[k].rem_v < (REM_W'(stg_reg[k].ma) << 1)),
            "divider remainder out of range")
        `CMFS_ASSERT_NXT(a_stage_hold, vld_reg[k] && !en,
            vld_reg[k] && $stable(stg_reg[k]), "divider stage changed while stalled")
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_data  = stg_reg[DIV_STAGES-1];

endmodule

// ----- sv/cube_map_face_select.sv -----
// ----------------------------------------------------------------------------
// Cube-map face select: top level
// Major-axis face pick and per-face u/v in unsigned 0.16 fixed point.
// ----------------------------------------------------------------------------
// One direction request is taken every clock while the output is not stalled.
// The pipeline holds one stage for magnitudes and axis compares, one for face,
// s/t and numerators, then the restoring divider at two quotient bits per
// stage, then the output register. All stages share one enable, so a result
// held at the output stalls the whole pipeline without losing or repeating
// any request.
`include "cube_map_face_select_defines.svh"

module cube_map_face_select import cmfs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cmfs_in_if.sink      dir,
    cmfs_out_if.source   coord
);

    logic en;

    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
    cmfs_s1_t         s1_next;
    cmfs_s1_t         s1_reg;
    logic             s1_vld_reg;

    logic signed [COMP_BITS-1:0] major;
    logic signed [EXT_W-1:0]     s_c;
    logic signed [EXT_W-1:0]     t_c;
    logic signed [EXT_W-1:0]     ma_s;
    logic [REM_W-1:0]            num_u;
    logic [REM_W-1:0]            num_v;
    logic [MAG_W-1:0]            ma;
    cmfs_face_t                  face_c;
    cmfs_div_t                   s2_next;
    cmfs_div_t                   s2_reg;
    logic                        s2_vld_reg;

    logic      div_vld;
    cmfs_div_t div_out;

    logic               coord_vld_reg;
    cmfs_face_t         face_reg;
    logic [UV_BITS-1:0] u_reg;
    logic [UV_BITS-1:0] v_reg;
    logic               zero_reg;

    assign en        = !coord_vld_reg || coord.ready;
    assign dir.ready = en;

    // stage 1: magnitudes and major-axis compares
    always_comb
    begin
        ax = comp_mag(dir.dir_x);
        ay = comp_mag(dir.dir_y);
        az = comp_mag(dir.dir_z);
        s1_next.x       = dir.dir_x;
        s1_next.y       = dir.dir_y;
        s1_next.z       = dir.dir_z;
        s1_next.x_major = (ax > ay) && (ax > az);
        s1_next.y_major = (ay > az);
        s1_next.zero    = (ax == '0) && (ay == '0) && (az == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= dir.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    // stage 2: face, in-plane components, numerators s + ma and t + ma
    always_comb
    begin
        if (s1_reg.x_major)
        begin
            major = s1_reg.x;
            t_c   = EXT_W'(s1_reg.y);
            if (s1_reg.x > 0)
            begin
                face_c = FACE_POS_X;
                s_c    = EXT_W'(s1_reg.z);
            end
            else
            begin
                face_c = FACE_NEG_X;
                s_c    = -EXT_W'(s1_reg.z);
            end
        end
        else if (s1_reg.y_major)
        begin
            major = s1_reg.y;
            s_c   = EXT_W'(s1_reg.x);
            if (s1_reg.y > 0)
            begin
                face_c = FACE_POS_Y;
                t_c    = EXT_W'(s1_reg.z);
            end
            else
            begin
                face_c = FACE_NEG_Y;
                t_c    = -EXT_W'(s1_reg.z);
            end
        end
        else
        begin
            major = s1_reg.z;
            t_c   = EXT_W'(s1_reg.y);
            if (s1_reg.z > 0)
            begin
                face_c = FACE_POS_Z;
                s_c    = -EXT_W'(s1_reg.x);
            end
            else
            begin
                face_c = FACE_NEG_Z;
                s_c    = EXT_W'(s1_reg.x);
            end
        end
        ma    = comp_mag(major);
        ma_s  = $signed({1'b0, ma});
        num_u = REM_W'(unsigned'(s_c + ma_s));
        num_v = REM_W'(unsigned'(t_c + ma_s));

        s2_next.side.face  = face_c;
        s2_next.side.zero  = s1_reg.zero;
        s2_next.side.sat_u = (s_c == ma_s);
        s2_next.side.sat_v = (t_c == ma_s);
        s2_next.ma         = ma;
        s2_next.rem_u      = num_u;
        s2_next.rem_v      = num_v;
        s2_next.quo_u      = '0;
        s2_next.quo_v      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    cmfs_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .in_data   (s2_reg),
        .out_valid (div_vld),
        .out_data  (div_out)
    );

    // output register: saturation and zero-vector override
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            coord_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face_reg <= div_out.side.face;
            zero_reg <= div_out.side.zero;
            if (div_out.side.zero)
            begin
                u_reg <= '0;
                v_reg <= '0;
            end
            else
            begin
                u_reg <= div_out.side.sat_u ? '1 : div_out.quo_u;
                v_reg <= div_out.side.sat_v ? '1 : div_out.quo_v;
            end
        end
    end

    assign coord.valid       = coord_vld_reg;
    assign coord.face        = face_reg;
    assign coord.u_coord     = u_reg;
    assign coord.v_coord     = v_reg;
    assign coord.zero_vector = zero_reg;

    `CMFS_ASSERT_IMP(a_zero_uv, coord.valid && coord.zero_vector,
        coord.u_coord == '0 && coord.v_coord == '0, "zero vector with nonzero u/v")
    `CMFS_ASSERT_IMP(a_num_range, s2_vld_reg && !s2_reg.side.zero,
        s2_reg.rem_u <= (REM_W'(s2_reg.ma) << 1) && s2_reg.rem_v <= (REM_W'(s2_reg.ma) << 1),
        "numerator exceeds twice the major magnitude")
    `CMFS_ASSERT_IMP(a_ma_zero, s2_vld_reg,
        (s2_reg.ma == '0) == s2_reg.side.zero, "major magnitude and zero flag disagree")
    `CMFS_ASSERT_NXT(a_s1_hold, s1_vld_reg && !en,
        s1_vld_reg && $stable(s1_reg), "stage 1 changed while stalled")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Cube-map face select: testbench
// Sends direction requests through the valid/ready channel and checks each
// result against an expected face/uv (typed in the table or from a predictor),
// kept in order in a queue. A short directed table covers zero vectors,
// extremes, ties and saturation. Random requests then follow in four
// handshake phases: no idling, sender idle, receiver stalled, and both.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cmfs_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int RAND_PER_PHASE = 460;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_DIRECTED   = 24;
    localparam longint UV_MAX     = (longint'(1) <<< UV_BITS) - 1;

    typedef struct packed {
        cmfs_face_t         face;
        logic [UV_BITS-1:0] u;
        logic [UV_BITS-1:0] v;
        logic               zero;
    } face_uv_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] x;
        logic signed [COMP_BITS-1:0] y;
        logic signed [COMP_BITS-1:0] z;
    } dir_t;

    typedef struct packed {
        dir_t     d;
        logic     typed;
        face_uv_t exp;
    } stim_row_t;

    localparam face_uv_t NO_EXP = '{FACE_POS_X, '0, '0, 1'b0};

    localparam stim_row_t DIR_TABLE [NUM_DIRECTED] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{FACE_NEG_Z, 16'd0, 16'd0, 1'b1}},
        '{'{16'sd32767, 16'sd0, 16'sd0}, 1'b1, '{FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
        '{'{-16'sd32768, 16'sd0, 16'sd0}, 1'b1, '{FACE_NEG_X, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b1, '{FACE_POS_Y, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd0, -16'sd32768, 16'sd0}, 1'b1, '{FACE_NEG_Y, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1, '{FACE_POS_Z, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd0, 16'sd0, -16'sd32768}, 1'b1, '{FACE_NEG_Z, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd1, 16'sd0, 16'sd0}, 1'b1, '{FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
        '{'{-16'sd1, 16'sd0, 16'sd0}, 1'b1, '{FACE_NEG_X, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd0, 16'sd0, -16'sd1}, 1'b1, '{FACE_NEG_Z, 16'd32768, 16'd32768, 1'b0}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
          '{FACE_POS_Z, 16'd0, 16'd65535, 1'b0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b1,
          '{FACE_NEG_Z, 16'd0, 16'd0, 1'b0}},
        '{'{16'sd1, 16'sd1, 16'sd1}, 1'b1, '{FACE_POS_Z, 16'd0, 16'd65535, 1'b0}},
        '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b1, '{FACE_NEG_Z, 16'd0, 16'd0, 1'b0}},
        '{'{-16'sd32768, 16'sd32767, 16'sd32767}, 1'b1,
          '{FACE_NEG_X, 16'd1, 16'd65535, 1'b0}},
        '{'{16'sd32767, -16'sd32768, 16'sd0}, 1'b1,
          '{FACE_NEG_Y, 16'd65535, 16'd32768, 1'b0}},
        '{'{16'sd100, 16'sd100, 16'sd5}, 1'b0, NO_EXP},
        '{'{16'sd5, -16'sd100, 16'sd100}, 1'b0, NO_EXP},
        '{'{-16'sd100, 16'sd5, -16'sd100}, 1'b0, NO_EXP},
        '{'{16'sd500, 16'sd500, -16'sd20}, 1'b0, NO_EXP},
        '{'{-16'sd32768, -16'sd32768, 16'sd0}, 1'b0, NO_EXP},
        '{'{16'sd0, -16'sd1, 16'sd1}, 1'b0, NO_EXP},
        '{'{16'sd3, -16'sd7, 16'sd2}, 1'b0, NO_EXP},
        '{'{-16'sd12345, 16'sd23456, -16'sd30000}, 1'b0, NO_EXP}
    };

    localparam int PHASE_SEND_IDLE [4]  = '{0, 76, 0, 31};
    localparam int PHASE_RECV_STALL [4] = '{0, 0, 76, 31};

    logic clk = 1'b0;
    logic rst_n;

    cmfs_in_if  dir_if ();
    cmfs_out_if coord_if ();

    cube_map_face_select DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .dir   (dir_if),
        .coord (coord_if)
    );

    always #2 clk = ~clk;

    face_uv_t face_uv_q [$];
    int       fail_count     = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    function automatic logic [UV_BITS-1:0] uv_fixed(longint c, longint m);
        longint q;
        q = ((c + m) <<< UV_BITS) / (2 * m);
        return (q > UV_MAX) ? UV_BITS'(UV_MAX) : UV_BITS'(q);
    endfunction

    function automatic face_uv_t predict_face_uv(dir_t d);
        longint   sx, sy, sz, ax, ay, az, ma, s, t;
        face_uv_t r;
        sx = d.x;
        sy = d.y;
        sz = d.z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        if (ax > ay && ax > az)
        begin
            ma = ax;
            if (sx > 0)
            begin
                r.face = FACE_POS_X; s = sz; t = sy;
            end
            else
            begin
                r.face = FACE_NEG_X; s = -sz; t = sy;
            end
        end
        else if (ay > az)
        begin
            ma = ay;
            if (sy > 0)
            begin
                r.face = FACE_POS_Y; s = sx; t = sz;
            end
            else
            begin
                r.face = FACE_NEG_Y; s = sx; t = -sz;
            end
        end
        else
        begin
            ma = az;
            if (sz > 0)
            begin
                r.face = FACE_POS_Z; s = -sx; t = sy;
            end
            else
            begin
                r.face = FACE_NEG_Z; s = sx; t = sy;
            end
        end
        r.zero = (ma == 0);
        r.u    = r.zero ? '0 : uv_fixed(s, ma);
        r.v    = r.zero ? '0 : uv_fixed(t, ma);
        return r;
    endfunction

    function automatic logic signed [COMP_BITS-1:0] pick_corner();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic dir_t random_dir();
        dir_t d;
        int   kind;
        kind = $urandom_range(0, 99);
        d.x  = COMP_BITS'($urandom);
        d.y  = COMP_BITS'($urandom);
        d.z  = COMP_BITS'($urandom);
        if (kind < 15)
        begin
            d.x = COMP_BITS'(int'($urandom_range(0, 32)) - 16);
            d.y = COMP_BITS'(int'($urandom_range(0, 32)) - 16);
            d.z = COMP_BITS'(int'($urandom_range(0, 32)) - 16);
        end
        else if (kind < 20)
        begin
            d.y = $urandom_range(0, 1) ? d.x : -d.x;
            d.z = $urandom_range(0, 1) ? d.x : -d.x;
        end
        if (kind >= 10 && kind < 40)
        begin
            // equal magnitudes on two axes
            case ($urandom_range(0, 2))
                0: d.y = $urandom_range(0, 1) ? d.x : -d.x;
                1: d.z = $urandom_range(0, 1) ? d.y : -d.y;
                default: d.x = $urandom_range(0, 1) ? d.z : -d.z;
            endcase
        end
        else if (kind < 55)
        begin
            if (kind >= 40)
            begin
                d.x = pick_corner();
                d.y = pick_corner();
                d.z = pick_corner();
            end
        end
        else if (kind < 65)
        begin
            if (kind == 55 || $urandom_range(0, 1)) d.x = '0;
            if (kind == 55 || $urandom_range(0, 1)) d.y = '0;
            if (kind == 55 || $urandom_range(0, 1)) d.z = '0;
        end
        return d;
    endfunction

    task automatic send_dir(input dir_t d, input face_uv_t exp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            dir_if.valid <= 1'b0;
            @(posedge clk);
        end
        dir_if.valid <= 1'b1;
        dir_if.dir_x <= d.x;
        dir_if.dir_y <= d.y;
        dir_if.dir_z <= d.z;
        do @(posedge clk); while (!dir_if.ready);
        face_uv_q.push_back(exp);
    endtask

    always @(posedge clk)
        coord_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        face_uv_t want;
        if (rst_n && coord_if.valid && coord_if.ready)
        begin
            if (face_uv_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result face=%0d u=%0d v=%0d zero=%0b",
                         $time, coord_if.face, coord_if.u_coord,
                         coord_if.v_coord, coord_if.zero_vector);
            end
            else
            begin
                want = face_uv_q.pop_front();
                if (coord_if.face !== want.face || coord_if.u_coord !== want.u ||
                    coord_if.v_coord !== want.v || coord_if.zero_vector !== want.zero)
                begin
                    fail_count++;
                    $display({"%0t: expected face=%0d u=%0d v=%0d zero=%0b, ",
                              "actual face=%0d u=%0d v=%0d zero=%0b"},
                             $time, want.face, want.u, want.v, want.zero,
                             coord_if.face, coord_if.u_coord, coord_if.v_coord,
                             coord_if.zero_vector);
                end
            end
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        dir_t d;
        rst_n          <= 1'b0;
        dir_if.valid   <= 1'b0;
        dir_if.dir_x   <= '0;
        dir_if.dir_y   <= '0;
        dir_if.dir_z   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            if (p == 0)
            begin
                for (int i = 0; i < NUM_DIRECTED; i++)
                    send_dir(DIR_TABLE[i].d, DIR_TABLE[i].typed ? DIR_TABLE[i].exp
                                                                : predict_face_uv(DIR_TABLE[i].d));
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                d = random_dir();
                send_dir(d, predict_face_uv(d));
            end
        end
        dir_if.valid <= 1'b0;

        while (face_uv_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
